@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge, quiet while rst_n is low.
`define SCI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check an implication on every rising clk edge, quiet while rst_n is low.
`define SCI_ASSERT_IMPL(label, pre, post, msg) \
    `SCI_ASSERT(label, (pre) |-> (post), msg)

`endif

@@ rtl/sci_pkg.sv @@
package sci_pkg;

    // Register stages between request and result, the result register included.
    localparam int unsigned NUM_STAGES = 6;

    typedef logic [NUM_STAGES-1:0] stage_vec_t;

    // Per-request decisions made once the sums are known.
    typedef struct packed {
        logic len_zero;   // segment has zero length
        logic start_in;   // start point strictly within the radius
        logic end_in;     // either endpoint strictly within the radius
        logic across;     // centre projects onto the segment
    } geo_flags_t;

endpackage

@@ rtl/sci_in_if.sv @@
interface sci_in_if #(
    parameter int COORD_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] radius;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;

    modport source (
        output valid, radius, center_x, center_y, start_x, start_y, end_x, end_y,
        input  ready
    );

    modport sink (
        input  valid, radius, center_x, center_y, start_x, start_y, end_x, end_y,
        output ready
    );
endinterface

@@ rtl/sci_out_if.sv @@
interface sci_out_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (
        output valid, hit,
        input  ready
    );

    modport sink (
        input  valid, hit,
        output ready
    );
endinterface

@@ rtl/segment_circle_intersect.sv @@
// Segment versus circle contact test. Each request carries a circle (radius,
// centre) and a segment (start, end) and yields one result, hit, which is set
// when the perpendicular distance from the centre to the segment's line is
// strictly below the radius and either the centre projects onto the segment or
// an endpoint lies strictly inside the circle; a zero-length segment hits only
// if its point is strictly inside. Math is exact integer: cross^2 is compared
// against radius^2 * |seg|^2 with no division or root. A new request is taken
// every cycle while the pipeline is not stalled; the stages, in order, are
// differences, narrow products, sums and signs, split partial products of the
// wide squares, wide sums, then the compare into the result register. Each
// stage holds its request while the stage after it is full and stalled, so
// empty stages keep filling while a result waits at the output.
`include "assert_macros.svh"

module segment_circle_intersect #(
    parameter int COORD_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    sci_in_if.sink       item,
    sci_out_if.source    result
);

    localparam int N  = COORD_BITS;
    localparam int DW = N + 1;          // coordinate difference
    localparam int PW = 2 * N + 2;      // products and their sums
    localparam int H  = PW / 2;         // half of a PW-bit value
    localparam int RW = 2 * N;          // radius squared
    localparam int WW = 2 * PW;         // wide squares
    localparam int NS = sci_pkg::NUM_STAGES;

    // ------------------------------------------------------------------
    // Stage flow control
    // ------------------------------------------------------------------
    sci_pkg::stage_vec_t vld_reg;
    sci_pkg::stage_vec_t vld_next;
    logic [NS:0]         rdy;
    logic [NS-1:0]       vld_in;

    always_comb
    begin
        rdy[NS] = result.ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign vld_in = {vld_reg[NS-2:0], item.valid};

    always_comb
    begin
        for (int k = 0; k < NS; k++)
        begin
            vld_next[k] = rdy[k] ? vld_in[k] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign item.ready   = rdy[0];
    assign result.valid = vld_reg[NS-1];

    // ------------------------------------------------------------------
    // Stage 1: coordinate differences
    // ------------------------------------------------------------------
    logic signed [DW-1:0] cx, cy, ax, ay, bx, by;
    logic signed [DW-1:0] sgx_next, sgy_next, scx_next, scy_next, ecx_next, ecy_next;
    logic        [N-1:0]  rad1_reg;
    logic signed [DW-1:0] sgx_reg, sgy_reg, scx_reg, scy_reg, ecx_reg, ecy_reg;

    assign cx = {item.center_x[N-1], item.center_x};
    assign cy = {item.center_y[N-1], item.center_y};
    assign ax = {item.start_x[N-1], item.start_x};
    assign ay = {item.start_y[N-1], item.start_y};
    assign bx = {item.end_x[N-1], item.end_x};
    assign by = {item.end_y[N-1], item.end_y};

    assign sgx_next = bx - ax;
    assign sgy_next = by - ay;
    assign scx_next = cx - ax;
    assign scy_next = cy - ay;
    assign ecx_next = cx - bx;
    assign ecy_next = cy - by;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            rad1_reg <= item.radius;
            sgx_reg  <= sgx_next;
            sgy_reg  <= sgy_next;
            scx_reg  <= scx_next;
            scy_reg  <= scy_next;
            ecx_reg  <= ecx_next;
            ecy_reg  <= ecy_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: narrow products
    // ------------------------------------------------------------------
    logic signed [PW-1:0] xc1_next, xc2_next, lx_next, ly_next;
    logic signed [PW-1:0] sx2_next, sy2_next, ex2_next, ey2_next;
    logic signed [PW-1:0] d1a_next, d1b_next, d2a_next, d2b_next;
    logic        [RW-1:0] r2_next;

    logic signed [PW-1:0] xc1_reg, xc2_reg, lx_reg, ly_reg;
    logic signed [PW-1:0] sx2_reg, sy2_reg, ex2_reg, ey2_reg;
    logic signed [PW-1:0] d1a_reg, d1b_reg, d2a_reg, d2b_reg;
    logic        [RW-1:0] r2a_reg;

    assign xc1_next = sgx_reg * scy_reg;
    assign xc2_next = sgy_reg * scx_reg;
    assign lx_next  = sgx_reg * sgx_reg;
    assign ly_next  = sgy_reg * sgy_reg;
    assign sx2_next = scx_reg * scx_reg;
    assign sy2_next = scy_reg * scy_reg;
    assign ex2_next = ecx_reg * ecx_reg;
    assign ey2_next = ecy_reg * ecy_reg;
    assign d1a_next = scx_reg * sgx_reg;
    assign d1b_next = scy_reg * sgy_reg;
    assign d2a_next = ecx_reg * sgx_reg;
    assign d2b_next = ecy_reg * sgy_reg;
    assign r2_next  = rad1_reg * rad1_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            xc1_reg <= xc1_next;
            xc2_reg <= xc2_next;
            lx_reg  <= lx_next;
            ly_reg  <= ly_next;
            sx2_reg <= sx2_next;
            sy2_reg <= sy2_next;
            ex2_reg <= ex2_next;
            ey2_reg <= ey2_next;
            d1a_reg <= d1a_next;
            d1b_reg <= d1b_next;
            d2a_reg <= d2a_next;
            d2b_reg <= d2b_next;
            r2a_reg <= r2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sums, cross magnitude and projection signs
    // ------------------------------------------------------------------
    logic        [PW-1:0] len2, s_d2, e_d2, r2_wide;
    logic signed [PW-1:0] d1, d2;
    logic        [PW-1:0] ac_next;
    sci_pkg::geo_flags_t  flags3_next;

    logic        [PW-1:0] ac3_reg, len3_reg;
    logic        [RW-1:0] r2b_reg;
    sci_pkg::geo_flags_t  flags3_reg;

    assign len2    = $unsigned(lx_reg) + $unsigned(ly_reg);
    assign s_d2    = $unsigned(sx2_reg) + $unsigned(sy2_reg);
    assign e_d2    = $unsigned(ex2_reg) + $unsigned(ey2_reg);
    assign r2_wide = PW'(r2a_reg);
    assign d1      = d1a_reg + d1b_reg;
    assign d2      = d2a_reg + d2b_reg;

    // Subtract in the order that keeps the result non-negative.
    assign ac_next = (xc1_reg >= xc2_reg) ? $unsigned(xc1_reg - xc2_reg)
                                          : $unsigned(xc2_reg - xc1_reg);

    always_comb
    begin
        flags3_next.len_zero = (len2 == '0);
        flags3_next.start_in = (s_d2 < r2_wide);
        flags3_next.end_in   = (s_d2 < r2_wide) || (e_d2 < r2_wide);
        flags3_next.across   = (d1 == '0) || (d2 == '0) || (d1[PW-1] != d2[PW-1]);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            ac3_reg    <= ac_next;
            len3_reg   <= len2;
            r2b_reg    <= r2a_reg;
            flags3_reg <= flags3_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: partial products of cross^2 and r^2 * len^2
    // ------------------------------------------------------------------
    logic [H-1:0]     ah, al, lh, ll;
    logic [N-1:0]     rh, rl;
    logic [2*H-1:0]   ahh_next, ahl_next, all_next;
    logic [N+H-1:0]   rhlh_next, rhll_next, rllh_next, rlll_next;

    logic [2*H-1:0]   ahh_reg, ahl_reg, all_reg;
    logic [N+H-1:0]   rhlh_reg, rhll_reg, rllh_reg, rlll_reg;
    sci_pkg::geo_flags_t flags4_reg;

    assign ah = ac3_reg[PW-1:H];
    assign al = ac3_reg[H-1:0];
    assign lh = len3_reg[PW-1:H];
    assign ll = len3_reg[H-1:0];
    assign rh = r2b_reg[RW-1:N];
    assign rl = r2b_reg[N-1:0];

    assign ahh_next  = ah * ah;
    assign ahl_next  = ah * al;
    assign all_next  = al * al;
    assign rhlh_next = rh * lh;
    assign rhll_next = rh * ll;
    assign rllh_next = rl * lh;
    assign rlll_next = rl * ll;

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            ahh_reg    <= ahh_next;
            ahl_reg    <= ahl_next;
            all_reg    <= all_next;
            rhlh_reg   <= rhlh_next;
            rhll_reg   <= rhll_next;
            rllh_reg   <= rllh_next;
            rlll_reg   <= rlll_next;
            flags4_reg <= flags3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: assemble the wide squares
    // ------------------------------------------------------------------
    logic [WW-1:0] lhs_next, rhs_next;
    logic [WW-1:0] lhs_reg, rhs_reg;
    sci_pkg::geo_flags_t flags5_reg;

    // The middle term of (ah*2^H + al)^2 appears twice: shift one extra place.
    assign lhs_next = {ahh_reg, all_reg} + (WW'(ahl_reg) << (H + 1));
    assign rhs_next = (WW'(rhlh_reg) << (N + H)) + (WW'(rhll_reg) << N)
                    + (WW'(rllh_reg) << H) + WW'(rlll_reg);

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            lhs_reg    <= lhs_next;
            rhs_reg    <= rhs_next;
            flags5_reg <= flags4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: final decision into the result register
    // ------------------------------------------------------------------
    logic hit_next;
    logic hit_reg;

    always_comb
    begin
        if (flags5_reg.len_zero)
        begin
            hit_next = flags5_reg.start_in;
        end
        else
        begin
            hit_next = (lhs_reg < rhs_reg) && (flags5_reg.across || flags5_reg.end_in);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            hit_reg <= hit_next;
        end
    end

    assign result.hit = hit_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `SCI_ASSERT(a_accept_fills_first, (item.valid && item.ready) |=> vld_reg[0], "accepted request did not enter stage 1")
    `SCI_ASSERT_IMPL(a_zero_len_no_cross, vld_reg[2] && flags3_reg.len_zero, ac3_reg == '0, "zero-length segment with nonzero cross product")
    `SCI_ASSERT_IMPL(a_zero_len_wide, vld_reg[4] && flags5_reg.len_zero, (lhs_reg == '0) && (rhs_reg == '0), "zero-length segment with nonzero wide squares")

endmodule

@@ verif/sci_checker.sv @@
module sci_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  logic [15:0] radius,
    input  logic [15:0] center_x,
    input  logic [15:0] center_y,
    input  logic [15:0] start_x,
    input  logic [15:0] start_y,
    input  logic [15:0] end_x,
    input  logic [15:0] end_y,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  logic        hit,
    output int          errors,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic hit_expected[$];

    // Exact integer contact test: squared line distance against radius, plus
    // the projection or endpoint-inside condition.
    function automatic logic segment_touches(
        input logic [15:0] rad,
        input logic [15:0] cxu,
        input logic [15:0] cyu,
        input logic [15:0] axu,
        input logic [15:0] ayu,
        input logic [15:0] bxu,
        input logic [15:0] byu
    );
        longint       cx, cy, ax, ay, bx, by;
        longint       seg_x, seg_y, sc_x, sc_y, ec_x, ec_y;
        longint       r_sq, start_sq, end_sq, len_sq, cross_val, dot_s, dot_e;
        logic [127:0] cross_mag, cross_sq, r_sq_w, len_sq_w, reach_sq;
        logic         near_end, across;

        cx = $signed(cxu);
        cy = $signed(cyu);
        ax = $signed(axu);
        ay = $signed(ayu);
        bx = $signed(bxu);
        by = $signed(byu);
        r_sq = rad;
        r_sq = r_sq * r_sq;

        seg_x = bx - ax;
        seg_y = by - ay;
        sc_x  = cx - ax;
        sc_y  = cy - ay;
        ec_x  = cx - bx;
        ec_y  = cy - by;

        start_sq = sc_x * sc_x + sc_y * sc_y;
        end_sq   = ec_x * ec_x + ec_y * ec_y;
        len_sq   = seg_x * seg_x + seg_y * seg_y;

        // A degenerate segment is just a point.
        if (len_sq == 0)
            return start_sq < r_sq;

        cross_val = seg_x * sc_y - seg_y * sc_x;
        cross_mag = (cross_val < 0) ? -cross_val : cross_val;
        cross_sq  = cross_mag * cross_mag;
        r_sq_w    = r_sq;
        len_sq_w  = len_sq;
        reach_sq  = r_sq_w * len_sq_w;

        dot_s    = sc_x * seg_x + sc_y * seg_y;
        dot_e    = ec_x * seg_x + ec_y * seg_y;
        across   = (dot_s == 0) || (dot_e == 0) || ((dot_s < 0) != (dot_e < 0));
        near_end = (start_sq < r_sq) || (end_sq < r_sq);

        return (cross_sq < reach_sq) && (across || near_end);
    endfunction

    always @(posedge clk)
    begin
        logic want;
        if (!rst_n)
        begin
            errors      <= 0;
            outstanding <= 0;
        end
        else
        begin
            // Retire before queuing so a result with nothing waiting is caught.
            if (rsp_valid && rsp_ready)
            begin
                if (hit_expected.size() == 0)
                begin
                    $error("hit arrived with no request outstanding: actual %0b", hit);
                    errors <= errors + 1;
                end
                else
                begin
                    want = hit_expected.pop_front();
                    if (hit !== want)
                    begin
                        $error("hit mismatch: expected %0b, actual %0b", want, hit);
                        errors <= errors + 1;
                    end
                end
            end
            if (req_valid && req_ready)
                hit_expected.push_back(segment_touches(radius, center_x, center_y,
                                                       start_x, start_y, end_x, end_y));
            outstanding <= hit_expected.size();
        end
    end
endmodule

@@ verif/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS = 16;
    localparam int RANDOM_REQUESTS = 500;

    typedef struct packed {
        logic [15:0] radius;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [15:0] start_x;
        logic [15:0] start_y;
        logic [15:0] end_x;
        logic [15:0] end_y;
    } probe_t;

    logic clk;
    logic rst_n;
    int   errors;
    int   outstanding;
    int   burst_left;

    sci_in_if #(.COORD_BITS(COORD_BITS)) req_ch ();
    sci_out_if                           res_ch ();

    segment_circle_intersect #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (req_ch),
        .result (res_ch)
    );

    sci_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_ch.valid),
        .req_ready   (req_ch.ready),
        .radius      (req_ch.radius),
        .center_x    (req_ch.center_x),
        .center_y    (req_ch.center_y),
        .start_x     (req_ch.start_x),
        .start_y     (req_ch.start_y),
        .end_x       (req_ch.end_x),
        .end_y       (req_ch.end_y),
        .rsp_valid   (res_ch.valid),
        .rsp_ready   (res_ch.ready),
        .hit         (res_ch.hit),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic probe_t probe(int r, int cx, int cy, int sx, int sy, int ex, int ey);
        probe_t p;
        p.radius   = r[15:0];
        p.center_x = cx[15:0];
        p.center_y = cy[15:0];
        p.start_x  = sx[15:0];
        p.start_y  = sy[15:0];
        p.end_x    = ex[15:0];
        p.end_y    = ey[15:0];
        return p;
    endfunction

    function automatic int clip(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic int signed_rand(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic int edge_coord();
        case ($urandom_range(0, 3))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            default: return signed_rand(32767);
        endcase
    endfunction

    function automatic probe_t random_probe();
        int r, cx, cy, reach, px, py;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                // Tiny grid: distances often land exactly on the radius.
                return probe($urandom_range(0, 12), signed_rand(8), signed_rand(8),
                             signed_rand(8), signed_rand(8), signed_rand(8), signed_rand(8));
            end
            3, 4, 5:
            begin
                r     = $urandom_range(0, 4000);
                cx    = signed_rand(20000);
                cy    = signed_rand(20000);
                reach = 2 * r + 10;
                return probe(r, cx, cy,
                             clip(cx + signed_rand(reach)), clip(cy + signed_rand(reach)),
                             clip(cx + signed_rand(reach)), clip(cy + signed_rand(reach)));
            end
            6, 7:
            begin
                return probe($urandom_range(0, 65535), signed_rand(32767), signed_rand(32767),
                             $urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom_range(0, 65535), $urandom_range(0, 65535));
            end
            8:
            begin
                // Degenerate segment near the centre.
                r  = $urandom_range(0, 300);
                cx = signed_rand(32767);
                cy = signed_rand(32767);
                px = clip(cx + signed_rand(r + 5));
                py = clip(cy + signed_rand(r + 5));
                return probe(r, cx, cy, px, py, px, py);
            end
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       r = 0;
                    1:       r = 65535;
                    2:       r = 1;
                    default: r = $urandom_range(0, 65535);
                endcase
                return probe(r, edge_coord(), edge_coord(), edge_coord(), edge_coord(),
                             edge_coord(), edge_coord());
            end
        endcase
    endfunction

    task automatic send_probe(probe_t p);
        req_ch.valid    <= 1'b1;
        req_ch.radius   <= p.radius;
        req_ch.center_x <= p.center_x;
        req_ch.center_y <= p.center_y;
        req_ch.start_x  <= p.start_x;
        req_ch.start_y  <= p.start_y;
        req_ch.end_x    <= p.end_x;
        req_ch.end_y    <= p.end_y;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Drop valid for a random gap once the current burst runs out.
    task automatic pace();
        int gap;
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 5);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Receiver back-pressure: switch between stall styles every so often.
    initial
    begin
        int mode;
        int phase_left;
        int tick;
        res_ch.ready <= 1'b0;
        mode       = 0;
        phase_left = 0;
        tick       = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (phase_left <= 0)
            begin
                mode       = $urandom_range(0, 3);
                phase_left = $urandom_range(20, 200);
            end
            phase_left--;
            tick++;
            case (mode)
                0:       res_ch.ready <= 1'b1;
                1:       res_ch.ready <= 1'($urandom_range(0, 1));
                2:       res_ch.ready <= ($urandom_range(0, 3) == 0);
                default: res_ch.ready <= (tick % 8) < 3;
            endcase
        end
    end

    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        probe_t directed[$];

        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.radius   <= '0;
        req_ch.center_x <= '0;
        req_ch.center_y <= '0;
        req_ch.start_x  <= '0;
        req_ch.start_y  <= '0;
        req_ch.end_x    <= '0;
        req_ch.end_y    <= '0;
        burst_left = $urandom_range(1, 40);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // zero radius never hits, point segments, tangent lines, endpoint on
        // the circle, projection landing on an endpoint, extremes
        directed.push_back(probe(0, 0, 0, 0, 0, 0, 0));
        directed.push_back(probe(1, 0, 0, 0, 0, 0, 0));
        directed.push_back(probe(5, 0, 0, 3, 4, 3, 4));
        directed.push_back(probe(6, 0, 0, 3, 4, 3, 4));
        directed.push_back(probe(5, 0, 0, -10, 5, 10, 5));
        directed.push_back(probe(6, 0, 0, -10, 5, 10, 5));
        directed.push_back(probe(5, 0, 0, 3, 4, 30, 40));
        directed.push_back(probe(6, 0, 0, 3, 4, 30, 40));
        directed.push_back(probe(4, 0, 0, 0, 3, 10, 3));
        directed.push_back(probe(3, 0, 0, 0, 3, 10, 3));
        directed.push_back(probe(5, 0, 0, 10, 0, 20, 0));
        directed.push_back(probe(11, 0, 0, 10, 0, 20, 0));
        directed.push_back(probe(11, 0, 0, 20, 0, 10, 0));
        directed.push_back(probe(1, 100, 100, 0, 200, 200, 0));
        directed.push_back(probe(0, 100, 100, 0, 200, 200, 0));
        directed.push_back(probe(65535, -32768, -32768, 32767, 32767, 32767, -32768));
        directed.push_back(probe(65535, 32767, 32767, -32768, -32768, 32767, 32767));
        directed.push_back(probe(65535, 0, 0, -32768, 0, 32767, 0));
        directed.push_back(probe(1, -32768, 32767, 32767, -32768, -32768, -32768));
        directed.push_back(probe(65535, 32767, 32767, 32767, 32767, 32767, 32767));
        directed.push_back(probe(32768, -32768, -32768, -32768, -32768, -32768, -32768));
        directed.push_back(probe(65535, -32768, -32768, 32767, 32767, 32767, 32767));

        foreach (directed[i])
        begin
            send_probe(directed[i]);
            pace();
        end
        drain();

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            send_probe(random_probe());
            pace();
            // Hold off mid-run until the pipeline is empty.
            if (n == RANDOM_REQUESTS / 2)
                drain();
        end

        drain();
        repeat (4 * sci_pkg::NUM_STAGES) @(posedge clk);

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/sci_pkg.sv
rtl/sci_in_if.sv
rtl/sci_out_if.sv
rtl/segment_circle_intersect.sv
verif/sci_checker.sv
verif/tb_top.sv
